### design/fct_pkg.sv
// Shared types and codes for the future completion table.
`timescale 1ns / 1ps

package fct_pkg;

  localparam int IN_W  = 152;
  localparam int OUT_W = 136;

  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_AWAIT   = 3'd1;
  localparam logic [2:0] CMD_FULFILL = 3'd2;
  localparam logic [2:0] CMD_REJECT  = 3'd3;
  localparam logic [2:0] CMD_HALT    = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  localparam logic [1:0] FS_PENDING  = 2'd0;
  localparam logic [1:0] FS_RESOLVED = 2'd1;
  localparam logic [1:0] FS_REJECTED = 2'd2;

  localparam logic [1:0] OP_PASS   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_AWAIT  = 2'd2;
  localparam logic [1:0] OP_SETTLE = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] idx;
    logic [63:0] value;
    logic [63:0] caller;
    logic [1:0]  status;
    logic [1:0]  settle_state;
    logic        halt;
  } work_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [63:0] result;
    logic        waiter_present;
    logic [63:0] waiter_id;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data;
    logic [1:0]  entry_outcome;
    logic        wake_valid;
    logic [31:0] wake_scheduler_id;
    logic [31:0] wake_local_pid;
    logic        halt;
  } result_t;

endpackage

### design/fct_front.sv
// Front end: accepts commands, checks handles and allocates entries.
`timescale 1ns / 1ps

module fct_front import fct_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_data,
  input  logic              q_full,
  output logic              push,
  output work_t             push_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] entries_used;
  logic [CNT_W-1:0] entries_used_next;
  logic [2:0]       command;
  logic [15:0]      handle;
  logic             handle_ok;
  logic             table_full;

  assign command    = in_data[2:0];
  assign handle     = in_data[18:3];
  assign handle_ok  = 32'(handle) < 32'(entries_used);
  assign table_full = 32'(entries_used) >= 32'(TABLE_DEPTH);
  assign in_ready   = !q_full;
  assign push       = in_valid && in_ready;

  always_comb begin
    push_data              = '0;
    push_data.idx          = handle;
    push_data.value        = in_data[82:19];
    push_data.caller       = {in_data[114:83], in_data[146:115]};
    push_data.op           = OP_PASS;
    push_data.status       = ST_DONE;
    push_data.settle_state = (command == CMD_REJECT) ? FS_REJECTED : FS_RESOLVED;
    push_data.halt         = (command == CMD_HALT);
    entries_used_next      = entries_used;
    case (command)
      CMD_CREATE: begin
        if (table_full) begin
          push_data.status = ST_FULL;
        end else begin
          push_data.op      = OP_CREATE;
          push_data.idx     = 16'(entries_used);
          entries_used_next = entries_used + CNT_W'(1);
        end
      end
      CMD_AWAIT: begin
        if (handle_ok) push_data.op = OP_AWAIT;
        else push_data.status = ST_INVALID;
      end
      CMD_FULFILL, CMD_REJECT, CMD_HALT: begin
        if (handle_ok) push_data.op = OP_SETTLE;
        else push_data.status = ST_INVALID;
      end
      default: begin
        push_data.op = OP_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (push) begin
      entries_used <= entries_used_next;
    end
  end

endmodule

### design/fct_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps

module fct_queue import fct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty
);

  work_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/fct_back.sv
// Back end: entry memory read-modify-write and result register.
`timescale 1ns / 1ps

module fct_back import fct_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  work_t   q_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  entry_t     mem [TABLE_DEPTH];
  entry_t     rd;
  entry_t     wdata;
  work_t      cur;
  logic       busy;
  logic       fire;
  logic       we;
  result_t    res;

  assign pop  = !busy && !q_empty;
  assign fire = busy && (!out_valid || out_ready);

  always_comb begin
    res               = '0;
    res.halt          = cur.halt;
    wdata             = rd;
    we                = 1'b0;
    case (cur.op)
      OP_CREATE: begin
        wdata      = '0;
        wdata.state = FS_PENDING;
        we         = 1'b1;
        res.status = ST_DONE;
        res.data   = 64'(cur.idx);
      end
      OP_AWAIT: begin
        if (rd.state == FS_PENDING) begin
          wdata.waiter_present = 1'b1;
          wdata.waiter_id      = cur.caller;
          we                   = 1'b1;
          res.status           = ST_BLOCKED;
          res.entry_outcome    = FS_PENDING;
        end else begin
          res.status        = ST_DONE;
          res.data          = rd.result;
          res.entry_outcome = rd.state;
        end
      end
      OP_SETTLE: begin
        wdata.state          = cur.settle_state;
        wdata.result         = cur.value;
        wdata.waiter_present = 1'b0;
        wdata.waiter_id      = '0;
        we                   = 1'b1;
        res.status           = ST_DONE;
        if (rd.waiter_present) begin
          res.wake_valid        = 1'b1;
          res.wake_scheduler_id = rd.waiter_id[63:32];
          res.wake_local_pid    = rd.waiter_id[31:0];
        end
      end
      default: begin
        res.status = cur.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && we) mem[cur.idx[IDX_W-1:0]] <= wdata;
    if (pop) rd <= mem[q_data.idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
    if (fire) out_result <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) busy <= 1'b1;
      else if (fire) busy <= 1'b0;
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_pop_starts: assert property (@(posedge clk) disable iff (rst) pop |=> busy)
    else $error("pop did not start an item");
  a_fire_ends: assert property (@(posedge clk) disable iff (rst) fire |=> !busy && out_valid)
    else $error("finished item left no result");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    busy && out_valid && !out_ready |=> busy)
    else $error("item dropped while output stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !pop)
    else $error("pop while an item is in flight");

endmodule

### design/future_completion_table_unit.sv
// Top level of the future completion table.
//
// Commands arrive on the s_ stream, one beat per command; each gives exactly
// one result beat on the m_ stream, in order.
// The front end checks the handle against the allocated count and allocates
// new entries; a two-beat queue passes classified commands to the back end,
// which reads the entry from a single-port-read memory, updates it and
// registers the result.
// The back end serves one command at a time: it reads the entry memory, then
// writes the entry back, before it takes the next command from the queue.
// Reset clears the allocated count, the queue and the result valid flag; the
// entry memory is not cleared, since every entry is written on create before
// its contents are used.
// When the receiver stalls, the result is held, the back end stops after its
// next read, and s_tready falls once the queue fills.
`timescale 1ns / 1ps

module future_completion_table_unit import fct_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // command[2:0], handle[18:3], value[82:19], caller_scheduler_id[114:83],
  // caller_local_pid[146:115], zero[151:147]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[1:0], data[65:2], entry_outcome[67:66], wake_valid[68],
  // wake_scheduler_id[100:69], wake_local_pid[132:101], halt[133], zero[135:134]
  output logic [OUT_W-1:0] m_tdata
);

  logic    push;
  work_t   push_data;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  work_t   q_data;
  result_t result;

  fct_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  fct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  fct_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {2'b00, result.halt, result.wake_local_pid, result.wake_scheduler_id,
                    result.wake_valid, result.entry_outcome, result.data, result.status};

endmodule

### dv/future_completion_table_unit_test.sv
// Self-checking stream testbench for the future completion table with a built-in table predictor.
`timescale 1ns / 1ps

module future_completion_table_unit_test;
  import fct_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ONE_END = 700;
  localparam int PHASE_TWO_END = 1400;
  localparam int HOLD_START = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;
  localparam logic [15:0] HANDLE_MAX = 16'hFFFF;
  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
  localparam logic [63:0] VALUE_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  logic [IN_W-1:0] pending_commands[$];
  result_t expected_results[$];
  int beats_sent = 0;
  int mismatches = 0;
  int gen_used = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int send_idle_pct;
  int recv_idle_pct;

  int used_count = 0;
  logic [1:0] entry_state_q[TABLE_DEPTH];
  logic [63:0] entry_value_q[TABLE_DEPTH];
  logic waiter_flag_q[TABLE_DEPTH];
  logic [63:0] waiter_id_q[TABLE_DEPTH];

  future_completion_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  always_comb begin
    if (beats_sent < PHASE_ONE_END) begin
      send_idle_pct = 36;
      recv_idle_pct = 81;
    end else if (beats_sent < PHASE_TWO_END) begin
      send_idle_pct = 81;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic result_t apply_command(input logic [IN_W-1:0] beat);
    result_t r;
    logic [2:0] cmd;
    logic [15:0] hnd;
    logic [63:0] val;
    logic ok;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] fresh;
    cmd = beat[2:0];
    hnd = beat[18:3];
    val = beat[82:19];
    r = '0;
    ok = int'(hnd) < used_count;
    slot = hnd[IDX_W-1:0];
    fresh = used_count[IDX_W-1:0];
    case (cmd)
      CMD_CREATE: begin
        if (used_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entry_state_q[fresh] = FS_PENDING;
          entry_value_q[fresh] = '0;
          waiter_flag_q[fresh] = 1'b0;
          waiter_id_q[fresh] = '0;
          r.status = ST_DONE;
          r.data = 64'(used_count);
          used_count++;
        end
      end
      CMD_AWAIT: begin
        if (!ok) begin
          r.status = ST_INVALID;
        end else if (entry_state_q[slot] == FS_PENDING) begin
          waiter_id_q[slot] = {beat[114:83], beat[146:115]};
          waiter_flag_q[slot] = 1'b1;
          r.status = ST_BLOCKED;
          r.entry_outcome = FS_PENDING;
        end else begin
          r.status = ST_DONE;
          r.data = entry_value_q[slot];
          r.entry_outcome = entry_state_q[slot];
        end
      end
      CMD_FULFILL, CMD_REJECT, CMD_HALT: begin
        if (!ok) begin
          r.status = ST_INVALID;
        end else begin
          entry_state_q[slot] = (cmd == CMD_REJECT) ? FS_REJECTED : FS_RESOLVED;
          entry_value_q[slot] = val;
          if (waiter_flag_q[slot]) begin
            r.wake_valid = 1'b1;
            r.wake_scheduler_id = waiter_id_q[slot][63:32];
            r.wake_local_pid = waiter_id_q[slot][31:0];
          end
          waiter_flag_q[slot] = 1'b0;
          waiter_id_q[slot] = '0;
          r.status = ST_DONE;
        end
        r.halt = (cmd == CMD_HALT);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_command(input logic [2:0] cmd, input logic [15:0] hnd,
                              input logic [63:0] val, input logic [31:0] sid,
                              input logic [31:0] lpid);
    pending_commands.push_back({5'b0, lpid, sid, val, hnd, cmd});
    if (cmd == CMD_CREATE && gen_used < TABLE_DEPTH) gen_used++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_command(s_tdata));
        beats_sent <= beats_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_commands.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && beats_sent >= HOLD_START) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat %0h with nothing expected", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, m_tdata[1:0]);
          check_field("data", want.data, m_tdata[65:2]);
          check_field("entry_outcome", want.entry_outcome, m_tdata[67:66]);
          check_field("wake_valid", want.wake_valid, m_tdata[68]);
          check_field("wake_scheduler_id", want.wake_scheduler_id, m_tdata[100:69]);
          check_field("wake_local_pid", want.wake_local_pid, m_tdata[132:101]);
          check_field("halt", want.halt, m_tdata[133]);
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int total;
    int pick;
    logic [2:0] cmd;
    logic [15:0] hnd;

    push_command(CMD_AWAIT, 16'd0, '0, WORD_ONES, WORD_ONES);
    push_command(CMD_FULFILL, HANDLE_MAX, VALUE_ONES, '0, '0);
    push_command(CMD_REJECT, 16'd0, VALUE_ONES, '0, '0);
    push_command(CMD_HALT, HANDLE_MAX, VALUE_ONES, WORD_ONES, WORD_ONES);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      push_command(3'(c), HANDLE_MAX, VALUE_ONES, WORD_ONES, WORD_ONES);
    push_command(CMD_CREATE, HANDLE_MAX, VALUE_ONES, WORD_ONES, WORD_ONES);
    push_command(CMD_CREATE, '0, '0, '0, '0);
    push_command(CMD_AWAIT, 16'd0, '0, WORD_ONES, '0);
    push_command(CMD_AWAIT, 16'd0, '0, '0, WORD_ONES);
    push_command(CMD_FULFILL, 16'd0, VALUE_ONES, '0, '0);
    push_command(CMD_AWAIT, 16'd0, '0, '0, '0);
    push_command(CMD_REJECT, 16'd0, '0, '0, '0);
    push_command(CMD_AWAIT, 16'd0, VALUE_ONES, '0, '0);
    push_command(CMD_AWAIT, 16'd1, '0, WORD_ONES, WORD_ONES);
    push_command(CMD_HALT, 16'd1, 64'h8000_0000_0000_0001, '0, '0);
    push_command(CMD_AWAIT, 16'd1, '0, '0, '0);
    push_command(CMD_AWAIT, 16'd2, '0, '0, '0);
    push_command(CMD_FULFILL, 16'd2, VALUE_ONES, '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CMD_CREATE;
      else if (pick < 55) cmd = CMD_AWAIT;
      else if (pick < 70) cmd = CMD_FULFILL;
      else if (pick < 85) cmd = CMD_REJECT;
      else if (pick < 93) cmd = CMD_HALT;
      else cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      pick = $urandom_range(0, 99);
      if (gen_used > 0 && pick < 75) hnd = 16'($urandom_range(0, gen_used - 1));
      else if (pick < 85) hnd = 16'(gen_used);
      else hnd = 16'($urandom);
      push_command(cmd, hnd, {$urandom, $urandom}, $urandom, $urandom);
    end
    total = pending_commands.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (beats_sent < total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
